@@ hdl/dead_reckoning_track_predictor_assert.svh @@
// Assertion macros used by the checker of the track predictor.
`ifndef DEAD_RECKONING_TRACK_PREDICTOR_ASSERT_SVH
`define DEAD_RECKONING_TRACK_PREDICTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRTP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("track predictor check failed");

// The consequent must hold in the cycle after the antecedent.
`define DRTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("track predictor check failed");

`endif

@@ hdl/drtp_pkg.sv @@
// Types, constants and tables of the dead-reckoning track predictor.
package drtp_pkg;

   localparam int MAX_STEPS    = 63;
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);

   localparam int STEP_W = 6;
   localparam int DT_W   = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STEPS = 1'd1;
   localparam logic [DT_W-1:0]   STEP_TIME_RESET = 16'd1000;
   localparam logic [STEP_W-1:0] NUM_STEPS_RESET = 6'd30;

   // CORDIC datapath: x and y in Q2.30 with headroom, z a 32-bit angle plus guard.
   localparam int CW = 34;
   localparam int ZW = 33;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // Rounding of the scaled product, then division by 1000 through a reciprocal
   // multiplication, which is exact for every 32-bit dividend.
   localparam logic [63:0] ROUND_HALF  = 64'd536870912000;
   localparam logic [31:0] RECIP_1000  = 32'd274877907;
   localparam int          RECIP_SHIFT = 38;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic [15:0]        heading;
      logic signed [15:0] speed;
   } drtp_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [STEP_W-1:0]  step_index;
      logic               last;
   } drtp_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SCALE,
      ST_MULT,
      ST_ROUND,
      ST_DIVIDE,
      ST_EMIT
   } drtp_state_type;

   // Arctangent of 2^-i as a 32-bit binary angle.
   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/dead_reckoning_track_predictor.sv @@
// Top level of the dead-reckoning track predictor: sequencer and shared datapath.
//
// Usage. A request beat on req_ (req_valid, req_stall, req_data) carries a start
// position, a course angle and a signed speed. The block answers with a run of
// response beats on rsp_ (rsp_valid, rsp_stall, rsp_data): the start point, then
// num_steps points each one step displacement further on, the final one flagged
// with last. Positions saturate at the signed 32-bit limits.
// Registers step_time_ms (index 0) and num_steps (index 1) are written through
// csr_wr_en, csr_index and csr_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce.
// Timing. req_stall is high from the beat after a request is taken until the
// last point of its run has been loaded into the output register. The per-step
// displacement takes CORDIC_ITERS iterations of CORDIC rotation, then speed
// times step time, then for x and for y one multiply, one rounding step and one
// reciprocal multiply for the division by 1000. The points of a run follow at
// one beat per cycle while rsp_stall is low.
// Stalls. A point waits in the output register while rsp_stall is high and the
// run pauses; the next request may be taken while the last point still waits.
// Reset clears the sequencer and the output valid and restores 1000 ms, 30 steps.
module dead_reckoning_track_predictor
   import drtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  drtp_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output drtp_rsp_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   drtp_state_type state_ff, state_in;

   logic [DT_W-1:0]   step_time_ff, step_time_in;
   logic [STEP_W-1:0] num_steps_ff, num_steps_in;

   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic signed [CW-1:0]   cx_ff, cx_in;
   logic signed [CW-1:0]   cy_ff, cy_in;
   logic signed [ZW-1:0]   cz_ff, cz_in;
   logic                   flip_ff, flip_in;
   logic                   spd_neg_ff, spd_neg_in;
   logic [15:0]            spd_mag_ff, spd_mag_in;
   logic [31:0]            sd_mag_ff, sd_mag_in;
   logic [63:0]            prod_ff, prod_in;
   logic                   prod_neg_ff, prod_neg_in;
   logic                   sel_y_ff, sel_y_in;
   logic [31:0]            div_n_ff, div_n_in;
   logic signed [31:0]     dx_ff, dx_in;
   logic signed [31:0]     dy_ff, dy_in;
   logic signed [31:0]     acc_x_ff, acc_x_in;
   logic signed [31:0]     acc_y_ff, acc_y_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [STEP_W-1:0]      nsteps_ff, nsteps_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   drtp_rsp_type           rsp_data_ff, rsp_data_in;

   // The one shared multiplier, used for speed times step time, for each trig product
   // and for the reciprocal of 1000.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // The CORDIC output in use: cos for x, then sin for y.
   logic signed [CW-1:0] trig;
   logic [CW-1:0]        trig_abs;

   assign mul_p    = mul_a * mul_b;
   assign trig     = sel_y_ff ? cy_ff : cx_ff;
   assign trig_abs = trig[CW-1] ? CW'(-trig) : CW'(trig);

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         return sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return sum[31:0];
   endfunction

   // Operand selection for the shared multiplier, by sequencer state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SCALE: begin
            mul_a = {16'h0000, spd_mag_ff};
            mul_b = {16'h0000, step_time_ff};
         end
         ST_MULT: begin
            mul_a = sd_mag_ff;
            mul_b = trig_abs[31:0];
         end
         ST_DIVIDE: begin
            mul_a = div_n_ff;
            mul_b = RECIP_1000;
         end
         default: ;
      endcase
   end

   always_comb begin
      logic signed [CW-1:0] xs, ys;
      logic signed [ZW-1:0] atan;
      logic [31:0]          ang_w, ang_f;
      logic                 req_flip, out_load, is_last;
      logic [63:0]          rnd_sum;
      logic [31:0]          quot;
      logic signed [31:0]   disp;

      state_in     = state_ff;
      step_time_in = step_time_ff;
      num_steps_in = num_steps_ff;
      iter_in      = iter_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      spd_neg_in   = spd_neg_ff;
      spd_mag_in   = spd_mag_ff;
      sd_mag_in    = sd_mag_ff;
      prod_in      = prod_ff;
      prod_neg_in  = prod_neg_ff;
      sel_y_in     = sel_y_ff;
      div_n_in     = div_n_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      step_in      = step_ff;
      nsteps_in    = nsteps_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      xs       = cx_ff >>> iter_ff;
      ys       = cy_ff >>> iter_ff;
      atan     = $signed({1'b0, atan_lookup(5'(iter_ff))});

      // Back half circle: turn by half a turn and negate the results later.
      ang_w    = {req_data.heading, 16'h0000};
      req_flip = req_data.heading[15] ^ req_data.heading[14];
      ang_f    = ang_w ^ {req_flip, 31'b0};

      out_load = !rsp_valid_ff || !rsp_stall;
      is_last  = (step_ff == nsteps_ff);

      rnd_sum = prod_ff + ROUND_HALF;
      quot    = 32'(mul_p >> RECIP_SHIFT);
      disp    = prod_neg_ff ? -$signed(quot) : $signed(quot);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_TIME: step_time_in = csr_wdata[DT_W-1:0];
            CSR_NUM_STEPS: num_steps_in = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_x_in   = req_data.start_x;
               acc_y_in   = req_data.start_y;
               spd_neg_in = req_data.speed[15];
               spd_mag_in = req_data.speed[15] ? 16'(-req_data.speed) : req_data.speed;
               flip_in    = req_flip;
               cx_in      = CORDIC_GAIN;
               cy_in      = '0;
               cz_in      = {ang_f[31], ang_f};
               iter_in    = '0;
               step_in    = '0;
               nsteps_in  = (num_steps_ff > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                                : num_steps_ff;
               sel_y_in   = 1'b0;
               state_in   = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            if (!cz_ff[ZW-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            sd_mag_in = mul_p[31:0];
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            prod_in     = mul_p;
            prod_neg_in = spd_neg_ff ^ trig[CW-1] ^ flip_ff;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            // Dividing by 1000 * 2^30 is a shift by 30 and then a division by 1000;
            // the shifted sum always fits in 32 bits.
            div_n_in = rnd_sum[61:30];
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sel_y_ff) begin
               dy_in    = disp;
               state_in = ST_EMIT;
            end else begin
               dx_in    = disp;
               sel_y_in = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.pos_x      = acc_x_ff;
               rsp_data_in.pos_y      = acc_y_ff;
               rsp_data_in.step_index = step_ff;
               rsp_data_in.last       = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  acc_x_in = sat_add(acc_x_ff, dx_ff);
                  acc_y_in = sat_add(acc_y_ff, dy_ff);
                  step_in  = step_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_time_ff <= STEP_TIME_RESET;
         num_steps_ff <= NUM_STEPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_time_ff <= step_time_in;
         num_steps_ff <= num_steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      flip_ff     <= flip_in;
      spd_neg_ff  <= spd_neg_in;
      spd_mag_ff  <= spd_mag_in;
      sd_mag_ff   <= sd_mag_in;
      prod_ff     <= prod_in;
      prod_neg_ff <= prod_neg_in;
      sel_y_ff    <= sel_y_in;
      div_n_ff    <= div_n_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      step_ff     <= step_in;
      nsteps_ff   <= nsteps_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/drtp_checker.sv @@
// Port-level checks of the track predictor and their binding to the top level.
`include "dead_reckoning_track_predictor_assert.svh"

module drtp_checker
   import drtp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input drtp_rsp_type rsp_data
);

   // A stalled beat keeps its value.
   `DRTP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A taken request keeps the block busy in the following cycle.
   `DRTP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // While a point that is not the last waits, the run is still in progress.
   `DRTP_ASSERT_SAME(a_busy_mid_run, rsp_valid && !rsp_data.last, req_stall)

   // Points of a run come in step order.
   `DRTP_ASSERT_NEXT(a_step_order, rsp_valid && !rsp_stall && !rsp_data.last,
      !rsp_valid || (rsp_data.step_index == 6'($past(rsp_data.step_index) + 1)))

endmodule

bind dead_reckoning_track_predictor drtp_checker u_drtp_checker (.*);
